[sv/mpeg_start_code_header_parser_unit_defines.svh]
// Assertion macros for the parser RTL; only the queue uses them.
`ifndef MPEG_START_CODE_HEADER_PARSER_UNIT_DEFINES_SVH
`define MPEG_START_CODE_HEADER_PARSER_UNIT_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define MSCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that must also hold during reset.
`define MSCP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/mscp_pkg.sv]
`default_nettype none
package mscp_pkg;

  localparam logic [2:0] KIND_SEQ   = 3'd0;
  localparam logic [2:0] KIND_GOP   = 3'd1;
  localparam logic [2:0] KIND_PIC   = 3'd2;
  localparam logic [2:0] KIND_SLICE = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  localparam logic [7:0] CODE_SEQ   = 8'hB3;
  localparam logic [7:0] CODE_GOP   = 8'hB8;
  localparam logic [7:0] CODE_PIC   = 8'h00;
  localparam logic [7:0] CODE_SLICE = 8'h01;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONE   = 8'h01;

  localparam int unsigned QUEUE_DEPTH = 2;

  // One finished unit, raw header bytes still packed.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] code;
    logic [7:0] hdr0;
    logic [7:0] hdr1;
    logic [7:0] hdr2;
    logic [7:0] last;
  } mscp_rec_t;

  typedef struct packed {
    logic      valid;
    mscp_rec_t rec;
  } mscp_push_t;

endpackage
`default_nettype wire

[sv/mscp_front.sv]
`default_nettype none
module mscp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        stream_byte_i,
  output mscp_pkg::mscp_push_t   push_o
);
  import mscp_pkg::*;

  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_CODE = 2'd1;
  localparam logic [1:0] PH_SEQ  = 2'd2;
  localparam logic [1:0] PH_PIC  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [1:0] zero_run_q, zero_run_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] hb_q [3];
  logic [7:0] hb_d [3];
  logic [7:0] code_q, code_d;

  always_comb begin
    phase_d    = phase_q;
    zero_run_d = zero_run_q;
    cnt_d      = cnt_q;
    hb_d       = hb_q;
    code_d     = code_q;
    push_o.valid     = 1'b0;
    push_o.rec.kind  = KIND_OTHER;
    push_o.rec.code  = code_q;
    push_o.rec.hdr0  = hb_q[0];
    push_o.rec.hdr1  = hb_q[1];
    push_o.rec.hdr2  = hb_q[2];
    push_o.rec.last  = stream_byte_i;
    if (accept_i) begin
      case (phase_q)
        PH_CODE: begin
          code_d = stream_byte_i;
          cnt_d  = 2'd0;
          if (stream_byte_i == CODE_SEQ) begin
            phase_d = PH_SEQ;
          end else if (stream_byte_i == CODE_PIC) begin
            phase_d = PH_PIC;
          end else begin
            push_o.valid    = 1'b1;
            push_o.rec.code = stream_byte_i;
            if (stream_byte_i == CODE_GOP) begin
              push_o.rec.kind = KIND_GOP;
            end else if (stream_byte_i == CODE_SLICE) begin
              push_o.rec.kind = KIND_SLICE;
            end else begin
              push_o.rec.kind = KIND_OTHER;
            end
            phase_d    = PH_SCAN;
            zero_run_d = 2'd0;
          end
        end
        PH_SEQ: begin
          if (cnt_q != 2'd3) begin
            hb_d[cnt_q] = stream_byte_i;
            cnt_d       = cnt_q + 2'd1;
          end else begin
            push_o.valid    = 1'b1;
            push_o.rec.kind = KIND_SEQ;
            phase_d    = PH_SCAN;
            zero_run_d = 2'd0;
            cnt_d      = 2'd0;
          end
        end
        PH_PIC: begin
          if (cnt_q == 2'd0) begin
            hb_d[0] = stream_byte_i;
            cnt_d   = 2'd1;
          end else begin
            push_o.valid    = 1'b1;
            push_o.rec.kind = KIND_PIC;
            phase_d    = PH_SCAN;
            zero_run_d = 2'd0;
            cnt_d      = 2'd0;
          end
        end
        default: begin
          // sliding prefix match: zeros saturate at two
          phase_d = PH_SCAN;
          if (stream_byte_i == BYTE_ZERO) begin
            if (zero_run_q != 2'd2) begin
              zero_run_d = zero_run_q + 2'd1;
            end
          end else if (stream_byte_i == BYTE_ONE && zero_run_q == 2'd2) begin
            zero_run_d = 2'd0;
            phase_d    = PH_CODE;
          end else begin
            zero_run_d = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      zero_run_q <= 2'd0;
      cnt_q      <= 2'd0;
    end else begin
      phase_q    <= phase_d;
      zero_run_q <= zero_run_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hb_q   <= hb_d;
    code_q <= code_d;
  end

endmodule
`default_nettype wire

[sv/mscp_queue.sv]
`default_nettype none
`include "mpeg_start_code_header_parser_unit_defines.svh"
module mscp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mscp_pkg::mscp_push_t push_i,
  input  wire logic                 pop_i,
  output logic                      full_o,
  output logic                      valid_o,
  output mscp_pkg::mscp_rec_t       rec_o
);
  import mscp_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  mscp_rec_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.valid && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i.valid && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.rec;
    end
  end

  `MSCP_ASSERT(a_cnt_bound, cnt_q <= CntFull, "queue count above depth")
  `MSCP_ASSERT(a_no_overflow, push_i.valid |-> !full_o, "word pushed into full queue")
  `MSCP_ASSERT(a_no_underflow, pop_i |-> valid_o, "word popped from empty queue")
  `MSCP_ASSERT(a_cnt_inc, push_i.valid && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1),
               "count did not advance on push")

endmodule
`default_nettype wire

[sv/mscp_back.sv]
`default_nettype none
module mscp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire mscp_pkg::mscp_rec_t rec_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [2:0]               unit_kind_o,
  output logic [7:0]               start_code_value_o,
  output logic [11:0]              frame_width_o,
  output logic [11:0]              frame_height_o,
  output logic [3:0]               rate_code_o,
  output logic [2:0]               coding_type_o
);
  import mscp_pkg::*;

  logic        valid_q;
  logic [2:0]  kind_q;
  logic [7:0]  code_q;
  logic [11:0] width_q, width_d;
  logic [11:0] height_q, height_d;
  logic [3:0]  rate_q, rate_d;
  logic [2:0]  ctype_q, ctype_d;

  assign pop_o = q_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    width_d  = 12'd0;
    height_d = 12'd0;
    rate_d   = 4'd0;
    ctype_d  = 3'd0;
    case (rec_i.kind)
      KIND_SEQ: begin
        width_d  = {rec_i.hdr0, rec_i.hdr1[7:4]};
        height_d = {rec_i.hdr1[3:0], rec_i.hdr2};
        rate_d   = rec_i.last[3:0];
      end
      KIND_PIC: begin
        ctype_d = rec_i.last[5:3];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= rec_i.kind;
      code_q   <= rec_i.code;
      width_q  <= width_d;
      height_q <= height_d;
      rate_q   <= rate_d;
      ctype_q  <= ctype_d;
    end
  end

  assign out_valid_o        = valid_q;
  assign unit_kind_o        = kind_q;
  assign start_code_value_o = code_q;
  assign frame_width_o      = width_q;
  assign frame_height_o     = height_q;
  assign rate_code_o        = rate_q;
  assign coding_type_o      = ctype_q;

endmodule
`default_nettype wire

[sv/mpeg_start_code_header_parser_unit.sv]
// A unit's finished record is written to the queue, then popped into the output registers.
// Throughput: one byte per cycle while not stalled; the front parser advances on accepted bytes.
// A two-word queue lets the parser keep taking bytes while an output word is stalled.
// Input stall rises only when that queue is full.
// Reset (rst_ni low, asynchronous): scanning for a prefix, no zeros counted, queue and output empty.
`default_nettype none
module mpeg_start_code_header_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  stream_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       unit_kind_o,
  output logic [7:0]       start_code_value_o,
  output logic [11:0]      frame_width_o,
  output logic [11:0]      frame_height_o,
  output logic [3:0]       rate_code_o,
  output logic [2:0]       coding_type_o
);
  import mscp_pkg::*;

  mscp_push_t push;
  mscp_rec_t  q_rec;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  mscp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .push_o        (push)
  );

  mscp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  mscp_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .rec_i              (q_rec),
    .pop_o              (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .unit_kind_o        (unit_kind_o),
    .start_code_value_o (start_code_value_o),
    .frame_width_o      (frame_width_o),
    .frame_height_o     (frame_height_o),
    .rate_code_o        (rate_code_o),
    .coding_type_o      (coding_type_o)
  );

endmodule
`default_nettype wire

[bench/tb_mpeg_start_code_header_parser_unit.sv]
`default_nettype none
module tb_mpeg_start_code_header_parser_unit;
  import mscp_pkg::*;

  typedef enum logic [1:0] {SCAN_PREFIX, TAKE_CODE, SEQ_HEADER, PIC_HEADER} parse_state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [11:0] width;
    logic [11:0] height;
    logic [3:0]  rate;
    logic [2:0]  ctype;
  } unit_word_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  stream_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  unit_kind;
  logic [7:0]  start_code_value;
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [3:0]  rate_code;
  logic [2:0]  coding_type;

  // predictor state
  logic [1:0]   zero_count;
  parse_state_e parse_state;
  logic [1:0]   hdr_count;
  logic [7:0]   hdr_bytes [3];
  logic [7:0]   unit_code;

  logic [7:0]  pending_bytes [$];
  unit_word_t  expected_units [$];
  bit          byte_taken;
  int          in_gap_left;
  int          stall_left;
  int          error_count;
  int          bytes_taken;
  int          unit_tally [5];

  mpeg_start_code_header_parser_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .stream_byte_i      (stream_byte),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .unit_kind_o        (unit_kind),
    .start_code_value_o (start_code_value),
    .frame_width_o      (frame_width),
    .frame_height_o     (frame_height),
    .rate_code_o        (rate_code),
    .coding_type_o      (coding_type)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [11:0] got, input logic [11:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  function automatic void parse_stream_byte(input logic [7:0] b);
    unit_word_t u;
    bit         found;
    u = '0;
    found = 1'b0;
    case (parse_state)
      TAKE_CODE: begin
        unit_code = b;
        hdr_count = 2'd0;
        if (b == CODE_SEQ) parse_state = SEQ_HEADER;
        else if (b == CODE_PIC) parse_state = PIC_HEADER;
        else begin
          found = 1'b1;
          u.code = b;
          u.kind = (b == CODE_GOP) ? KIND_GOP : (b == CODE_SLICE) ? KIND_SLICE : KIND_OTHER;
        end
      end
      SEQ_HEADER: begin
        if (hdr_count < 2'd3) begin
          hdr_bytes[hdr_count] = b;
          hdr_count++;
        end else begin
          found = 1'b1;
          u.kind = KIND_SEQ;
          u.code = unit_code;
          u.width = {hdr_bytes[0], hdr_bytes[1][7:4]};
          u.height = {hdr_bytes[1][3:0], hdr_bytes[2]};
          u.rate = b[3:0];
        end
      end
      PIC_HEADER: begin
        if (hdr_count == 2'd0) begin
          hdr_bytes[0] = b;
          hdr_count = 2'd1;
        end else begin
          found = 1'b1;
          u.kind = KIND_PIC;
          u.code = unit_code;
          u.ctype = b[5:3];
        end
      end
      default: begin
        // sliding match: extra zeros keep the count saturated at two
        if (b == BYTE_ZERO) begin
          if (zero_count < 2'd2) zero_count++;
        end else if (b == BYTE_ONE && zero_count == 2'd2) begin
          zero_count = 2'd0;
          parse_state = TAKE_CODE;
        end else begin
          zero_count = 2'd0;
        end
      end
    endcase
    if (found) begin
      expected_units.push_back(u);
      zero_count = 2'd0;
      hdr_count = 2'd0;
      parse_state = SCAN_PREFIX;
    end
  endfunction

  task automatic check_unit(input unit_word_t got);
    unit_word_t want;
    if (expected_units.size() == 0) begin
      report_mismatch($sformatf("unexpected unit kind %0d code %02h", got.kind, got.code));
    end else begin
      want = expected_units.pop_front();
      check_field("unit_kind", 12'(got.kind), 12'(want.kind));
      check_field("start_code_value", 12'(got.code), 12'(want.code));
      check_field("frame_width", got.width, want.width);
      check_field("frame_height", got.height, want.height);
      check_field("rate_code", 12'(got.rate), 12'(want.rate));
      check_field("coding_type", 12'(got.ctype), 12'(want.ctype));
      if (want.kind < 3'd5) unit_tally[want.kind]++;
    end
  endtask

  // sample both handshakes; predict on accepted bytes, check accepted words
  always @(posedge clk_i) begin
    byte_taken = rst_ni && in_valid && !in_stall;
    if (byte_taken) begin
      parse_stream_byte(stream_byte);
      bytes_taken++;
    end
    if (rst_ni && out_valid && !out_stall)
      check_unit('{unit_kind, start_code_value, frame_width, frame_height, rate_code,
                   coding_type});
  end

  // drive at the falling edge; no idling once the tail of the stream is reached
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || byte_taken) begin
        if (in_gap_left != 0) begin
          in_valid <= 1'b0;
          in_gap_left--;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 200 && $urandom_range(0, 7) == 0) begin
          in_gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          stream_byte <= pending_bytes.pop_front();
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (pending_bytes.size() > 200 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] header_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_prefix();
    int zeros;
    zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 6) : 2;
    repeat (zeros) pending_bytes.push_back(BYTE_ZERO);
    pending_bytes.push_back(BYTE_ONE);
  endfunction

  initial begin
    logic [7:0] lead_in [];
    lead_in = '{
      BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE, CODE_SEQ, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      BYTE_ZERO, BYTE_ZERO, BYTE_ONE, CODE_PIC, BYTE_ZERO, 8'h38,
      BYTE_ZERO, BYTE_ZERO, BYTE_ONE, CODE_GOP,
      BYTE_ZERO, BYTE_ONE, BYTE_ZERO, BYTE_ZERO, BYTE_ONE, CODE_SLICE,
      BYTE_ZERO, BYTE_ZERO, BYTE_ONE, 8'hFF
    };
    zero_count = '0;
    parse_state = SCAN_PREFIX;
    hdr_count = '0;
    unit_code = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    foreach (lead_in[i]) pending_bytes.push_back(lead_in[i]);

    while (pending_bytes.size() < 1930) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          push_prefix();
          pending_bytes.push_back(CODE_SEQ);
          repeat (4) pending_bytes.push_back(header_byte());
        end
        2, 3: begin
          push_prefix();
          pending_bytes.push_back(CODE_PIC);
          repeat (2) pending_bytes.push_back(header_byte());
        end
        4: begin
          push_prefix();
          pending_bytes.push_back(CODE_GOP);
        end
        5: begin
          push_prefix();
          pending_bytes.push_back(CODE_SLICE);
        end
        6: begin
          push_prefix();
          pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        7: begin
          // noise rich in zeros and ones, which forms broken and stray prefixes
          repeat ($urandom_range(1, 6))
            pending_bytes.push_back($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                                   : 8'($urandom_range(0, 1)));
        end
        8: begin
          pending_bytes.push_back(BYTE_ZERO);
          pending_bytes.push_back(BYTE_ONE);
        end
        default: push_prefix();
      endcase
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_units.size() != 0)
      report_mismatch($sformatf("%0d units never arrived", expected_units.size()));

    $display("Run fed %0d stream bytes and checked %0d sequence, %0d picture, %0d GOP,",
             bytes_taken, unit_tally[KIND_SEQ], unit_tally[KIND_PIC], unit_tally[KIND_GOP]);
    $display("%0d slice and %0d other units; %0d mismatches.",
             unit_tally[KIND_SLICE], unit_tally[KIND_OTHER], error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d units outstanding", expected_units.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
